@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the edge magnitude design.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication checked in the following cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/gem_pkg.sv @@
// ----------------------------------------------------------------------------
// gem_pkg
// Shared constants and types for the 3x3 gradient edge magnitude block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gem_pkg;

   // Image limits
   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 4096;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);

   // Field widths
   localparam int PIX_W        = 8;
   localparam int MAG_W        = 11;
   localparam int WIDTH_REG_W  = 12;
   localparam int HEIGHT_REG_W = 13;
   localparam int CSR_DATA_W   = 13;
   localparam int CSR_INDEX_W  = 2;

   // Register reset values
   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = WIDTH_REG_W'(640);
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = HEIGHT_REG_W'(480);
   localparam int MIN_DIM = 3;

   // Register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_KERNEL_MODE  = 2'd2
   } csr_index_type;

   // Kernel selection
   typedef enum logic {
      KERNEL_SOBEL   = 1'b0,
      KERNEL_PREWITT = 1'b1
   } kernel_mode_type;

   // Per-item control carried down the pipeline
   typedef struct packed {
      logic emit;   // full window, item gives a result
      logic last;   // final result of the frame
   } item_tag_type;

endpackage

`default_nettype wire

@@ sv/gradient_edge_magnitude_3x3.sv @@
// ----------------------------------------------------------------------------
// gradient_edge_magnitude_3x3
// Raster-stream 3x3 Sobel / Prewitt edge magnitude, valid-only convolution.
// ----------------------------------------------------------------------------
// Takes one 8-bit pixel per clock in raster order, unless req_stall holds
// it, and gives |Gx|+|Gy| for every window lying fully inside the frame,
// (width-2) x (height-2) results, with rsp_frame_last on the final one.
// Throughput is one pixel per cycle while no stall holds the flow. The
// accepting edge registers the line store read into stage 1, the window
// then shifts as the item moves into stage 2, and the gradient is then
// registered in the output register, stage 3; a stall can hold an item in
// any stage. Border pixels pass through the pipeline and give no result.
// Width and height outside 3..2048 and 3..4096 are saturated. The user must
// see that registers are written while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module gradient_edge_magnitude_3x3
   import gem_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // Configuration
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   // Pixel input
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [PIX_W-1:0]       req_pixel,
   // Result output
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic      [MAG_W-1:0]       rsp_magnitude,
   output logic                        rsp_frame_last
);

   // Configuration registers
   logic [WIDTH_REG_W-1:0]  width_ff;
   logic [HEIGHT_REG_W-1:0] height_ff;
   logic                    mode_ff;

   // Position counters
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   // Pipeline control
   logic             valid1_ff, valid2_ff;
   item_tag_type     tag1_ff, tag2_ff, tag_new;
   logic [PIX_W-1:0] pix1_ff;
   logic             rsp_valid_ff;
   logic [MAG_W-1:0] mag_ff;
   logic             last_ff;

   logic             accept, ready3, adv2, free2, move1;
   logic [COL_W-1:0] col_last;
   logic [ROW_W-1:0] row_last;
   logic [WIDTH_REG_W-1:0]  width_m1;
   logic [HEIGHT_REG_W-1:0] height_m1;
   logic             col_end, row_end;
   logic [PIX_W-1:0] up_pixel, mid_pixel;
   logic [MAG_W-1:0] magnitude;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         mode_ff   <= KERNEL_SOBEL;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= WIDTH_REG_W'(csr_wdata);
            CSR_IMAGE_HEIGHT: height_ff <= HEIGHT_REG_W'(csr_wdata);
            CSR_KERNEL_MODE:  mode_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Saturated last column and last row
   always_comb begin
      width_m1  = width_ff - WIDTH_REG_W'(1);
      height_m1 = height_ff - HEIGHT_REG_W'(1);
      priority if (int'(width_ff) < MIN_DIM) begin
         col_last = COL_W'(MIN_DIM - 1);
      end else if (int'(width_ff) > MAX_WIDTH) begin
         col_last = COL_W'(MAX_WIDTH - 1);
      end else begin
         col_last = COL_W'(width_m1);
      end
      priority if (int'(height_ff) < MIN_DIM) begin
         row_last = ROW_W'(MIN_DIM - 1);
      end else if (int'(height_ff) > MAX_HEIGHT) begin
         row_last = ROW_W'(MAX_HEIGHT - 1);
      end else begin
         row_last = ROW_W'(height_m1);
      end
   end

   // Handshake: stage 1 holds only when stage 2 cannot take its item
   always_comb begin
      ready3    = !rsp_valid_ff || !rsp_stall;
      adv2      = valid2_ff && (!tag2_ff.emit || ready3);
      free2     = !valid2_ff || adv2;
      move1     = valid1_ff && free2;
      req_stall = valid1_ff && !free2;
      accept    = req_valid && !req_stall;
   end

   // Position of this item and next counter values
   always_comb begin
      col_end      = col_ff >= col_last;
      row_end      = row_ff >= row_last;
      tag_new.emit = (int'(col_ff) >= 2) && (int'(row_ff) >= 2);
      tag_new.last = col_end && row_end;
      if (col_end) begin
         col_in = '0;
         row_in = row_end ? '0 : row_ff + ROW_W'(1);
      end else begin
         col_in = col_ff + COL_W'(1);
         row_in = row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Stage 1: line store read in flight
   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else if (!valid1_ff || move1) begin
         valid1_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         tag1_ff <= tag_new;
         pix1_ff <= req_pixel;
      end
   end

   // Stage 2: window shifted, gradient ready
   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff <= 1'b0;
      end else if (free2) begin
         valid2_ff <= move1;
      end
   end

   always_ff @(posedge clock) begin
      if (move1) begin
         tag2_ff <= tag1_ff;
      end
   end

   // Stage 3: result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ready3) begin
         rsp_valid_ff <= valid2_ff && tag2_ff.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (ready3 && valid2_ff && tag2_ff.emit) begin
         mag_ff  <= magnitude;
         last_ff <= tag2_ff.last;
      end
   end

   gem_line_store u_line_store (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (accept),
      .rd_addr   (col_ff),
      .wr_pixel  (req_pixel),
      .up_pixel  (up_pixel),
      .mid_pixel (mid_pixel)
   );

   gem_window u_window (
      .clock       (clock),
      .shift_en    (move1),
      .up_pixel    (up_pixel),
      .mid_pixel   (mid_pixel),
      .new_pixel   (pix1_ff),
      .kernel_mode (mode_ff),
      .magnitude   (magnitude)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_magnitude  = mag_ff;
   assign rsp_frame_last = last_ff;

   `ASSERT_IMPL(a_mag_range, clock, reset, rsp_valid_ff,
      mag_ff <= MAG_W'(2040), "magnitude above 2040")
   `ASSERT_IMPL(a_stall_needs_item, clock, reset, req_stall,
      valid1_ff && valid2_ff, "input stalled with stage 1 or 2 empty")
   `ASSERT_NEXT(a_accept_fills, clock, reset, accept,
      valid1_ff, "accepted item missing from stage 1")

endmodule

`default_nettype wire

@@ sv/gem_line_store.sv @@
// ----------------------------------------------------------------------------
// gem_line_store
// Two row memories with registered read; the upper row is written in the
// cycle after the read, with the old middle-row value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module gem_line_store
   import gem_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             rd_en,
   input  wire logic [COL_W-1:0] rd_addr,
   input  wire logic [PIX_W-1:0] wr_pixel,
   output logic      [PIX_W-1:0] up_pixel,
   output logic      [PIX_W-1:0] mid_pixel
);

   logic [PIX_W-1:0] up_mem  [MAX_WIDTH];
   logic [PIX_W-1:0] mid_mem [MAX_WIDTH];

   logic [PIX_W-1:0] up_rd_ff;
   logic [PIX_W-1:0] mid_rd_ff;
   logic             wr_pend_ff;
   logic [COL_W-1:0] wr_addr_ff;

   // Middle row: read old value and store the new pixel in the same cycle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         mid_rd_ff        <= mid_mem[rd_addr];
         mid_mem[rd_addr] <= wr_pixel;
      end
   end

   // Upper row: read now, write back the old middle value next cycle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         up_rd_ff <= up_mem[rd_addr];
      end
      if (wr_pend_ff) begin
         up_mem[wr_addr_ff] <= mid_rd_ff;
      end
   end

   // Pending write bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_pend_ff <= 1'b0;
      end else begin
         wr_pend_ff <= rd_en;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         wr_addr_ff <= rd_addr;
      end
   end

   assign up_pixel  = up_rd_ff;
   assign mid_pixel = mid_rd_ff;

   // Consecutive items always hit different columns, so the delayed write
   // never collides with a read
   `ASSERT_IMPL(a_no_rw_collision, clock, reset, rd_en && wr_pend_ff,
      rd_addr != wr_addr_ff, "line store read hits pending write column")

endmodule

`default_nettype wire

@@ sv/gem_window.sv @@
// ----------------------------------------------------------------------------
// gem_window
// 3x3 window register and the Sobel / Prewitt gradient magnitude.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gem_window
   import gem_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             shift_en,
   input  wire logic [PIX_W-1:0] up_pixel,
   input  wire logic [PIX_W-1:0] mid_pixel,
   input  wire logic [PIX_W-1:0] new_pixel,
   input  wire logic             kernel_mode,
   output logic      [MAG_W-1:0] magnitude
);

   localparam int SUM_W = PIX_W + 2;

   // Row-major window, newest column at the right
   logic [PIX_W-1:0] win_ff [9];

   logic [SUM_W-1:0]        gx_pos, gx_neg, gy_pos, gy_neg;
   logic signed [SUM_W:0]   gx, gy;
   logic [SUM_W-1:0]        gx_abs, gy_abs;

   // Shift one column in
   always_ff @(posedge clock) begin
      if (shift_en) begin
         win_ff[0] <= win_ff[1];
         win_ff[1] <= win_ff[2];
         win_ff[2] <= up_pixel;
         win_ff[3] <= win_ff[4];
         win_ff[4] <= win_ff[5];
         win_ff[5] <= mid_pixel;
         win_ff[6] <= win_ff[7];
         win_ff[7] <= win_ff[8];
         win_ff[8] <= new_pixel;
      end
   end

   // Centre weight applied to x: 2 for Sobel, 1 for Prewitt
   function automatic logic [SUM_W-1:0] weigh(input logic [PIX_W-1:0] x, input logic mode);
      logic [SUM_W-1:0] ext;
      ext = SUM_W'(x);
      return (mode == KERNEL_PREWITT) ? ext : (ext << 1);
   endfunction

   // Gradient sums and magnitude
   always_comb begin
      gx_pos = SUM_W'(win_ff[2]) + weigh(win_ff[5], kernel_mode) + SUM_W'(win_ff[8]);
      gx_neg = SUM_W'(win_ff[0]) + weigh(win_ff[3], kernel_mode) + SUM_W'(win_ff[6]);
      gy_pos = SUM_W'(win_ff[6]) + weigh(win_ff[7], kernel_mode) + SUM_W'(win_ff[8]);
      gy_neg = SUM_W'(win_ff[0]) + weigh(win_ff[1], kernel_mode) + SUM_W'(win_ff[2]);
      gx     = $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
      gy     = $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});
      gx_abs = gx[SUM_W] ? SUM_W'(-gx) : SUM_W'(gx);
      gy_abs = gy[SUM_W] ? SUM_W'(-gy) : SUM_W'(gy);
      magnitude = MAG_W'(gx_abs) + MAG_W'(gy_abs);
   end

endmodule

`default_nettype wire
